@@ sv/e2q_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

  // default configuration
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int COMP_WIDTH_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 14;

  // internal q30 formats
  localparam int XY_W = 33;
  localparam int Z_W  = 35;

  localparam logic signed [Z_W-1:0]  Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [Z_W-1:0]  Q30_PI      = 35'sd3373259426;
  localparam logic signed [XY_W-1:0] Q30_GAIN    = 33'sd652032874;

  // arctangent of 2^-i in q30
  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:       r = 35'sd843314856;
      1:       r = 35'sd497837829;
      2:       r = 35'sd263043836;
      3:       r = 35'sd133525158;
      4:       r = 35'sd67021686;
      5:       r = 35'sd33543515;
      6:       r = 35'sd16775850;
      7:       r = 35'sd8388437;
      8:       r = 35'sd4194282;
      9:       r = 35'sd2097149;
      default: r = Z_W'(64'sd1 <<< (30 - i));
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/e2q_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic
  import e2q_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int STAGES      = CORDIC_STAGES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle_i,
  output logic signed [XY_W-1:0]             sin_o,
  output logic signed [XY_W-1:0]             cos_o
);

  logic signed [Z_W-1:0]  half_w;
  logic signed [Z_W-1:0]  z_q [0:STAGES-1];
  logic signed [XY_W-1:0] x_q [1:STAGES];
  logic signed [XY_W-1:0] y_q [1:STAGES];
  logic                   f_q [0:STAGES];

  // half angle in q30 and range reduction into +-pi/2
  assign half_w = Z_W'(angle_i) <<< (33 - ANGLE_WIDTH);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (half_w > Q30_HALF_PI) begin
        z_q[0] <= half_w - Q30_PI;
        f_q[0] <= 1'b1;
      end else if (half_w < -Q30_HALF_PI) begin
        z_q[0] <= half_w + Q30_PI;
        f_q[0] <= 1'b1;
      end else begin
        z_q[0] <= half_w;
        f_q[0] <= 1'b0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] xp;
    logic signed [XY_W-1:0] yp;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   pos;

    if (i == 0) begin : g_first
      assign xp = Q30_GAIN;
      assign yp = '0;
    end else begin : g_next
      assign xp = x_q[i];
      assign yp = y_q[i];
    end

    assign xs  = xp >>> i;
    assign ys  = yp >>> i;
    assign pos = ~z_q[i][Z_W-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1] <= pos ? xp - ys : xp + ys;
        y_q[i+1] <= pos ? yp + xs : yp - xs;
        f_q[i+1] <= f_q[i];
      end
    end

    if (i < STAGES - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i+1] <= pos ? z_q[i] - atan_q30(i) : z_q[i] + atan_q30(i);
        end
      end
    end
  end

  // undo the range reduction by negation
  assign cos_o = f_q[STAGES] ? -x_q[STAGES] : x_q[STAGES];
  assign sin_o = f_q[STAGES] ? -y_q[STAGES] : y_q[STAGES];

endmodule
`default_nettype wire

@@ sv/e2q_combine.sv @@
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine
  import e2q_pkg::*;
#(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic signed [XY_W-1:0]       sin_y_i,
  input  wire logic signed [XY_W-1:0]       cos_y_i,
  input  wire logic signed [XY_W-1:0]       sin_p_i,
  input  wire logic signed [XY_W-1:0]       cos_p_i,
  input  wire logic signed [XY_W-1:0]       sin_r_i,
  input  wire logic signed [XY_W-1:0]       cos_r_i,
  output logic signed [COMP_WIDTH-1:0]      quat_x_o,
  output logic signed [COMP_WIDTH-1:0]      quat_y_o,
  output logic signed [COMP_WIDTH-1:0]      quat_z_o,
  output logic signed [COMP_WIDTH-1:0]      quat_w_o
);

  localparam int PW = 2 * XY_W;
  localparam int SW = PW + 1;
  localparam int SH = 62 - COMP_WIDTH;
  localparam logic signed [PW-1:0] PRND = PW'(64'sd1 <<< 29);
  localparam logic signed [SW-1:0] CRND = SW'(64'sd1) <<< (SH - 1);
  localparam logic signed [SW-1:0] LIM  = SW'(64'sd1) <<< (COMP_WIDTH - 2);

  logic signed [XY_W-1:0] cc_q, cs_q, sc_q, ss_q, sy_q, cy_q;
  logic signed [PW-1:0]   xa_q, xb_q, ya_q, yb_q, za_q, zb_q, wa_q, wb_q;

  function automatic logic signed [PW-1:0] mul_rnd(input logic signed [XY_W-1:0] a,
                                                   input logic signed [XY_W-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    return (p + PRND) >>> 30;
  endfunction

  function automatic logic signed [COMP_WIDTH-1:0] rnd_sat(input logic signed [PW-1:0] a,
                                                           input logic signed [PW-1:0] b,
                                                           input logic sub);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] r;
    s = sub ? SW'(a) - SW'(b) : SW'(a) + SW'(b);
    r = (s + CRND) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[COMP_WIDTH-1:0];
  endfunction

  // pair products of roll and pitch terms, yaw terms delayed to match
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= XY_W'(mul_rnd(cos_r_i, cos_p_i));
      cs_q <= XY_W'(mul_rnd(cos_r_i, sin_p_i));
      sc_q <= XY_W'(mul_rnd(sin_r_i, cos_p_i));
      ss_q <= XY_W'(mul_rnd(sin_r_i, sin_p_i));
      sy_q <= sin_y_i;
      cy_q <= cos_y_i;
    end
  end

  // q60 products with the yaw terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q <= cs_q * cy_q;
      xb_q <= sc_q * sy_q;
      ya_q <= cc_q * sy_q;
      yb_q <= ss_q * cy_q;
      za_q <= sc_q * cy_q;
      zb_q <= cs_q * sy_q;
      wa_q <= cc_q * cy_q;
      wb_q <= ss_q * sy_q;
    end
  end

  // sum, round and saturate into the output word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_x_o <= rnd_sat(xa_q, xb_q, 1'b0);
      quat_y_o <= rnd_sat(ya_q, yb_q, 1'b1);
      quat_z_o <= rnd_sat(za_q, zb_q, 1'b1);
      quat_w_o <= rnd_sat(wa_q, wb_q, 1'b0);
    end
  end

endmodule
`default_nettype wire

@@ sv/euler_to_quaternion_unit.sv @@
// throughput: one word per cycle while the output is not stalled; a range-reduction
// stage, one register per cordic micro-rotation, then pair products, yaw products
// and a round/saturate stage
// a stalled output freezes the whole pipeline in place
// reset (rst_ni low, asynchronous) clears only the valid bits of the pipeline
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_unit
  import e2q_pkg::*;
#(
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int COMP_WIDTH    = COMP_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int IN_TDW        = ((3 * ANGLE_WIDTH + 7) / 8) * 8,
  parameter int OUT_TDW       = ((4 * COMP_WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // angle_about_y, angle_about_x, angle_about_z
  input  wire logic [IN_TDW-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w
  output logic [OUT_TDW-1:0]      m_axis_tdata
);

  localparam int LAT = CORDIC_STAGES + 4;

  logic                         en;
  logic [LAT-1:0]               v_q;
  logic signed [XY_W-1:0]       s_y, c_y, s_p, c_p, s_r, c_r;
  logic signed [COMP_WIDTH-1:0] q_x, q_y, q_z, q_w;

  // global advance: output empty or being taken
  assign en            = ~v_q[LAT-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[LAT-1];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // half-angle sine and cosine per axis
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_cordic_y (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata[ANGLE_WIDTH-1:0]),
    .sin_o(s_y), .cos_o(c_y)
  );
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_cordic_x (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
    .sin_o(s_p), .cos_o(c_p)
  );
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_cordic_z (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]),
    .sin_o(s_r), .cos_o(c_r)
  );

  // quaternion assembly
  e2q_combine #(.COMP_WIDTH(COMP_WIDTH)) u_combine (
    .clk_i, .en_i(en),
    .sin_y_i(s_y), .cos_y_i(c_y), .sin_p_i(s_p), .cos_p_i(c_p),
    .sin_r_i(s_r), .cos_r_i(c_r),
    .quat_x_o(q_x), .quat_y_o(q_y), .quat_z_o(q_z), .quat_w_o(q_w)
  );

  assign m_axis_tdata = OUT_TDW'({q_w, q_z, q_y, q_x});

`ifndef NO_ASSERTIONS
  localparam logic signed [COMP_WIDTH-1:0] ALIM = COMP_WIDTH'(1) <<< (COMP_WIDTH - 2);

  // a stalled pipeline keeps its valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q)) else $error("valid bits moved during stall");

  // w and x components stay within plus or minus one
  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (q_w <= ALIM && q_w >= -ALIM && q_x <= ALIM && q_x >= -ALIM))
    else $error("component out of range");
`endif

endmodule
`default_nettype wire

@@ sim/euler_to_quaternion_unit_test.sv @@
`timescale 1ns / 1ps
module euler_to_quaternion_unit_test;
  import e2q_pkg::*;

  localparam int AW = ANGLE_WIDTH_DEF;
  localparam int CW = COMP_WIDTH_DEF;
  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = STAGES + 4;
  localparam int RANDOM_WORDS = 1930;

  typedef struct packed {
    logic [CW-1:0] w;
    logic [CW-1:0] z;
    logic [CW-1:0] y;
    logic [CW-1:0] x;
  } quat_t;

  typedef struct {
    logic [AW-1:0] yaw;
    logic [AW-1:0] pitch;
    logic [AW-1:0] roll;
    bit            typed;
    quat_t         quat;
  } angle_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [3*AW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [4*CW-1:0] m_axis_tdata;

  quat_t quat_fifo[$];
  int errors = 0;
  int words_sent = 0;
  int words_received = 0;
  bit sender_done = 1'b0;
  bit long_hold = 1'b0;

  euler_to_quaternion_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // floor shift of a signed value
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // arctangent of 2^-i in q30
  function automatic longint atan_table(int i);
    longint t[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                      33543515, 16775850, 8388437, 4194282, 2097149};
    return (i < 10) ? t[i] : (longint'(1) <<< (30 - i));
  endfunction

  // half-angle sine and cosine, q30
  task automatic half_sin_cos(input logic [AW-1:0] ang, output longint s, output longint c);
    longint z, x, y, xs, ys, at;
    bit flip;
    z = longint'($signed(ang)) * (longint'(1) <<< (33 - AW));
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES && i < 30; i++) begin
      at = longint'(atan_table(i));
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= at;
      end else begin
        x += ys; y -= xs; z += at;
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint mul_round_q30(longint a, longint b);
    return fshift(a * b + (longint'(1) <<< 29), 30);
  endfunction

  function automatic logic [CW-1:0] round_component(longint q60);
    int sh;
    longint lim, r;
    sh = 60 - (CW - 2);
    lim = longint'(1) <<< (CW - 2);
    r = fshift(q60 + (longint'(1) <<< (sh - 1)), sh);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[CW-1:0];
  endfunction

  // expected quaternion for one angle triple
  task automatic predict_quat(input logic [AW-1:0] yaw, pitch, roll, output quat_t q);
    longint sy, cy, sp, cp, sr, cr, crcp, crsp, srcp, srsp;
    half_sin_cos(yaw, sy, cy);
    half_sin_cos(pitch, sp, cp);
    half_sin_cos(roll, sr, cr);
    crcp = mul_round_q30(cr, cp);
    crsp = mul_round_q30(cr, sp);
    srcp = mul_round_q30(sr, cp);
    srsp = mul_round_q30(sr, sp);
    q.x = round_component(crsp * cy + srcp * sy);
    q.y = round_component(crcp * sy - srsp * cy);
    q.z = round_component(srcp * cy - crsp * sy);
    q.w = round_component(crcp * cy + srsp * sy);
  endtask

  // offer one word and wait for it to be taken
  task automatic send_angles(input logic [AW-1:0] yaw, pitch, roll, input quat_t q);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    quat_fifo.push_back(q);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {roll, pitch, yaw};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // random angle, biased toward extremes, zero and the half-pi boundaries
  function automatic logic [AW-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1: return 16'(12868 + $urandom_range(0, 8) - 4);
      2: return 16'(-12868 + $urandom_range(0, 8) - 4);
      3: return 16'($urandom_range(0, 15) - 8);
      default: return AW'($urandom());
    endcase
  endfunction

  // stimulus
  initial begin
    angle_row_t rows[$];
    angle_row_t r;
    quat_t q;
    logic [AW-1:0] a, b, c;
    rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h7fff, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h8000, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'h7fff, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'h8000, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'h0000, 16'h7fff, 1'b0, '0},
      '{16'h0000, 16'h0000, 16'h8000, 1'b0, '0},
      '{16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '0},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
      '{16'h7fff, 16'h8000, 16'h7fff, 1'b0, '0},
      '{16'd12868, 16'd12868, 16'd12868, 1'b0, '0},
      '{16'd12869, 16'hcdbb, 16'd12867, 1'b0, '0},
      '{16'hcdbc, 16'hcdbb, 16'hcdbd, 1'b0, '0},
      '{16'd25736, 16'd0, 16'd0, 1'b0, '0},
      '{16'd3217, 16'd3217, 16'd3217, 1'b0, '0},
      '{16'h0001, 16'hffff, 16'h5555, 1'b0, '0},
      '{16'haaaa, 16'h5555, 16'haaaa, 1'b0, '0},
      '{16'hffff, 16'hffff, 16'hffff, 1'b0, '0},
      '{16'h0000, 16'h3244, 16'h0000, 1'b0, '0},
      '{16'h3244, 16'h0000, 16'hcdbc, 1'b0, '0}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed table
    foreach (rows[i]) begin
      r = rows[i];
      if (r.typed) q = r.quat;
      else predict_quat(r.yaw, r.pitch, r.roll, q);
      send_angles(r.yaw, r.pitch, r.roll, q);
    end
    // let everything drain before the random part
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (quat_fifo.size() != 0);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // back-to-back burst into a held-off receiver
      if (n == 300) begin
        long_hold = 1'b1;
        for (int k = 0; k < 60; k++) begin
          a = AW'($urandom()); b = AW'($urandom()); c = AW'($urandom());
          predict_quat(a, b, c, q);
          quat_fifo.push_back(q);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {c, b, a};
          do @(posedge clk_i); while (!s_axis_tready);
          words_sent++;
        end
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (long_hold);
      end
      if (n == 1000) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (quat_fifo.size() != 0);
      end
      a = pick_angle(); b = pick_angle(); c = pick_angle();
      predict_quat(a, b, c, q);
      send_angles(a, b, c, q);
    end
    s_axis_tvalid <= 1'b0;
    sender_done = 1'b1;
  end

  // receiver stall control
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall == 0) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        do @(posedge clk_i); while (!(m_axis_tvalid || long_hold));
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      words_received++;
      if (quat_fifo.size() == 0) begin
        $error("unexpected word %h", got);
        errors++;
      end else begin
        want = quat_fifo.pop_front();
        if (got.x !== want.x) begin
          $error("quat_x expected %0d got %0d", $signed(want.x), $signed(got.x)); errors++;
        end
        if (got.y !== want.y) begin
          $error("quat_y expected %0d got %0d", $signed(want.y), $signed(got.y)); errors++;
        end
        if (got.z !== want.z) begin
          $error("quat_z expected %0d got %0d", $signed(want.z), $signed(got.z)); errors++;
        end
        if (got.w !== want.w) begin
          $error("quat_w expected %0d got %0d", $signed(want.w), $signed(got.w)); errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (sender_done);
    while (quat_fifo.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("%0d angle triples sent, %0d quaternions checked, including extremes,",
             words_sent, words_received);
    $display("half-pi wrap points, a long output hold and a full drain pause");
    if (errors == 0 && quat_fifo.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
sv/e2q_pkg.sv
sv/e2q_cordic.sv
sv/e2q_combine.sv
sv/euler_to_quaternion_unit.sv
sim/euler_to_quaternion_unit_test.sv
